[rtl/udpd_pkg.sv]
// ----------------------------------------------------------------------------
// udpd_pkg
// Shared codes and types of the UDP port demultiplexer: request kinds,
// response status codes, slot index type and the slot lookup bundle.
// ----------------------------------------------------------------------------
package udpd_pkg;

   // Widest slot index the design supports (up to 256 slots)
   localparam int MAX_SLOT_W = 8;
   // UDP header size in bytes
   localparam int HDR_BYTES  = 8;

   typedef logic [MAX_SLOT_W-1:0] slot_idx_type;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_RECEIVE = 2'd2,
      KIND_READ    = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_DELIVERED  = 4'd0,
      ST_AUTOBOUND  = 4'd1,
      ST_FULL_DROP  = 4'd2,
      ST_SHORT_DROP = 4'd3,
      ST_DATA       = 4'd4,
      ST_NODATA     = 4'd5,
      ST_BOUND      = 4'd6,
      ST_TABLE_FULL = 4'd7,
      ST_BYTE       = 4'd8
   } status_type;

   // Result of one parallel port lookup over the slot table
   typedef struct packed {
      logic         hit;
      slot_idx_type hit_idx;
      logic         free;
      slot_idx_type free_idx;
   } lookup_type;

endpackage

[rtl/udpd_ram.sv]
// ----------------------------------------------------------------------------
// udpd_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module udpd_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/udpd_slot_table.sv]
// ----------------------------------------------------------------------------
// udpd_slot_table
// Active flags and bound ports of all slots, with a parallel port match
// and a first-free search. Binds one slot per cycle on request.
// ----------------------------------------------------------------------------
module udpd_slot_table #(
   parameter int NUM_SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [15:0]           lookup_port,
   output udpd_pkg::lookup_type  lookup,
   input  logic                  bind_en,
   input  udpd_pkg::slot_idx_type bind_idx,
   input  logic [15:0]           bind_port
);

   import udpd_pkg::*;

   logic [NUM_SLOTS-1:0] active_ff;
   logic [NUM_SLOTS-1:0] active_in;
   logic [15:0]          port_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] match;

   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         match[i] = active_ff[i] && (port_ff[i] == lookup_port);
      end
   end

   // Lowest index wins for both searches
   always_comb begin
      lookup = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (match[i]) begin
            lookup.hit     = 1'b1;
            lookup.hit_idx = MAX_SLOT_W'(i);
         end
         if (!active_ff[i]) begin
            lookup.free     = 1'b1;
            lookup.free_idx = MAX_SLOT_W'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         active_in[i] = active_ff[i] || (bind_en && (bind_idx == MAX_SLOT_W'(i)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else begin
         active_ff <= active_in;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (bind_en && (bind_idx == MAX_SLOT_W'(i))) begin
            port_ff[i] <= bind_port;
         end
      end
   end

`ifndef SYNTHESIS
   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match))
      else $error("port bound to more than one slot");

   a_bind_needs_free: assert property (@(posedge clock) disable iff (reset)
      bind_en |-> lookup.free)
      else $error("bind with no free slot");

   a_active_grows: assert property (@(posedge clock) disable iff (reset)
      ##1 ($countones(active_ff) >= $past($countones(active_ff))))
      else $error("slot lost its binding");
`endif

endmodule

[rtl/udp_port_demux_buffer_top.sv]
// ----------------------------------------------------------------------------
// udp_port_demux_buffer_top
// UDP port demultiplexer with one datagram buffer per port slot. Headers
// bind or match a slot and arm a payload fill, payload bytes stream into
// the slot buffer, receive requests hand over and consume the stored
// length, and read requests fetch one buffered byte.
//
//  Channel | Ports  | Direction | Contents
//  --------+--------+-----------+-----------------------------------------
//  request | req_*  | in        | tuser: kind; tdata: header/payload/read
//  response| rsp_*  | out       | tuser: status; tdata: slot/count/byte
//
// Flow: header, payload and unbound-port receive requests finish in idle;
// receive requests on a bound port and read requests pass through S_WAIT
// for the registered read of the length memory or the payload memory.
// Reset: synchronous; clears slot bindings, the fill pointer and the
// response valid flag. Buffer bytes are undefined until written; no
// clearing pass runs. A new request is taken while a response waits,
// as long as the response register drains in the same cycle.
// ----------------------------------------------------------------------------
module udp_port_demux_buffer_top #(
   parameter int NUM_SLOTS = 16,
   parameter int BUF_BYTES = 2048
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // port[15:0], udp_length[31:16], seg_length[47:32], max_length[63:48],
   // data_byte[71:64], slot_index[75:72], byte_offset[86:76], zero[87]
   input  logic [87:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]  req_tuser,
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // slot[3:0], count[15:4], read_byte[23:16]
   output logic [23:0] rsp_tdata,
   // status[3:0]
   output logic [3:0]  rsp_tuser
);

   import udpd_pkg::*;

   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int OFF_W     = $clog2(BUF_BYTES);
   localparam int LEN_W     = $clog2(BUF_BYTES + 1);
   localparam int PAY_AW    = SLOT_W + OFF_W;
   localparam int PAY_DEPTH = 2 ** PAY_AW;

   typedef enum logic {
      S_IDLE,
      S_WAIT
   } state_type;

   // Request fields
   kind_type    req_kind;
   logic [15:0] req_port;
   logic [15:0] req_udp_length;
   logic [15:0] req_seg_length;
   logic [15:0] req_max_length;
   logic [7:0]  req_data_byte;
   logic [3:0]  req_slot_index;
   logic [10:0] req_byte_offset;

   assign req_kind        = kind_type'(req_tuser);
   assign req_port        = req_tdata[15:0];
   assign req_udp_length  = req_tdata[31:16];
   assign req_seg_length  = req_tdata[47:32];
   assign req_max_length  = req_tdata[63:48];
   assign req_data_byte   = req_tdata[71:64];
   assign req_slot_index  = req_tdata[75:72];
   assign req_byte_offset = req_tdata[86:76];

   // Registers
   state_type        state_ff, state_in;
   logic [SLOT_W-1:0] rx_slot_ff, rx_slot_in;
   logic [OFF_W-1:0]  rx_offset_ff, rx_offset_in;
   logic [LEN_W-1:0]  rx_remaining_ff, rx_remaining_in;
   logic              pend_read_ff, pend_read_in;
   slot_idx_type      pend_idx_ff, pend_idx_in;
   logic [15:0]       pend_max_ff, pend_max_in;
   logic              pend_in_range_ff, pend_in_range_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [3:0]        rsp_slot_ff, rsp_slot_in;
   logic [11:0]       rsp_count_ff, rsp_count_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;

   // Slot table
   lookup_type   lkp;
   logic         bind_en;
   slot_idx_type bind_idx;

   udpd_slot_table #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_slot_table (
      .clock       (clock),
      .reset       (reset),
      .lookup_port (req_port),
      .lookup      (lkp),
      .bind_en     (bind_en),
      .bind_idx    (bind_idx),
      .bind_port   (req_port)
   );

   // Stored length per slot
   logic              len_wr_en;
   logic [SLOT_W-1:0] len_wr_addr;
   logic [LEN_W-1:0]  len_wr_data;
   logic              len_rd_en;
   logic [LEN_W-1:0]  len_rd_data;

   udpd_ram #(
      .WIDTH (LEN_W),
      .DEPTH (NUM_SLOTS)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_wr_en),
      .wr_addr (len_wr_addr),
      .wr_data (len_wr_data),
      .rd_en   (len_rd_en),
      .rd_addr (lkp.hit_idx[SLOT_W-1:0]),
      .rd_data (len_rd_data)
   );

   // Payload buffers, one region of 2**OFF_W bytes per slot
   logic              pay_wr_en;
   logic              pay_rd_en;
   logic [PAY_AW-1:0] pay_rd_addr;
   logic [7:0]        pay_rd_data;

   udpd_ram #(
      .WIDTH (8),
      .DEPTH (PAY_DEPTH)
   ) u_pay_ram (
      .clock   (clock),
      .wr_en   (pay_wr_en),
      .wr_addr ({rx_slot_ff, rx_offset_ff}),
      .wr_data (req_data_byte),
      .rd_en   (pay_rd_en),
      .rd_addr (pay_rd_addr),
      .rd_data (pay_rd_data)
   );

   // Accept only in idle, and only when the response register is free
   // or drains this cycle.
   logic req_accept;
   logic rsp_free;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && rsp_free;
   assign req_accept = req_tvalid && req_tready;

   // Header length: UDP length minus header, floored at 0, clamped to buffer
   logic [16:0] dlen_raw;
   logic [16:0] dlen_clamp;
   logic [LEN_W-1:0] dlen;

   always_comb begin
      if (req_udp_length < 16'(HDR_BYTES)) begin
         dlen_raw = '0;
      end else begin
         dlen_raw = {1'b0, req_udp_length} - 17'(HDR_BYTES);
      end
      dlen_clamp = (dlen_raw > 17'(BUF_BYTES)) ? 17'(BUF_BYTES) : dlen_raw;
      dlen       = dlen_clamp[LEN_W-1:0];
   end

   // Read request address and range check
   logic [31:0] sidx_wide;
   logic [31:0] boff_wide;
   logic        read_in_range;

   assign sidx_wide     = 32'(req_slot_index);
   assign boff_wide     = 32'(req_byte_offset);
   assign read_in_range = (sidx_wide < 32'(NUM_SLOTS)) && (boff_wide < 32'(BUF_BYTES));
   assign pay_rd_addr   = {sidx_wide[SLOT_W-1:0], boff_wide[OFF_W-1:0]};

   // Receive: handed-over count
   logic [16:0] len_wide;
   logic [16:0] recv_n;

   assign len_wide = 17'(len_rd_data);
   assign recv_n   = (len_wide > {1'b0, pend_max_ff}) ? {1'b0, pend_max_ff} : len_wide;

   always_comb begin
      state_in         = state_ff;
      rx_slot_in       = rx_slot_ff;
      rx_offset_in     = rx_offset_ff;
      rx_remaining_in  = rx_remaining_ff;
      pend_read_in     = pend_read_ff;
      pend_idx_in      = pend_idx_ff;
      pend_max_in      = pend_max_ff;
      pend_in_range_in = pend_in_range_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_status_in    = rsp_status_ff;
      rsp_slot_in      = rsp_slot_ff;
      rsp_count_in     = rsp_count_ff;
      rsp_byte_in      = rsp_byte_ff;
      bind_en          = 1'b0;
      bind_idx         = lkp.free_idx;
      len_wr_en        = 1'b0;
      len_wr_addr      = lkp.hit_idx[SLOT_W-1:0];
      len_wr_data      = '0;
      len_rd_en        = 1'b0;
      pay_wr_en        = 1'b0;
      pay_rd_en        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (req_kind)
                  KIND_HEADER: begin
                     rsp_valid_in = 1'b1;
                     rsp_count_in = '0;
                     rsp_byte_in  = '0;
                     rsp_slot_in  = '0;
                     if (req_seg_length < 16'(HDR_BYTES)) begin
                        // cancel any pending fill
                        rsp_status_in   = ST_SHORT_DROP;
                        rx_remaining_in = '0;
                     end else if (!lkp.hit && !lkp.free) begin
                        rsp_status_in   = ST_FULL_DROP;
                        rx_remaining_in = '0;
                     end else begin
                        if (lkp.hit) begin
                           rsp_status_in = ST_DELIVERED;
                           len_wr_addr   = lkp.hit_idx[SLOT_W-1:0];
                           rx_slot_in    = lkp.hit_idx[SLOT_W-1:0];
                           rsp_slot_in   = lkp.hit_idx[3:0];
                        end else begin
                           rsp_status_in = ST_AUTOBOUND;
                           bind_en       = 1'b1;
                           len_wr_addr   = lkp.free_idx[SLOT_W-1:0];
                           rx_slot_in    = lkp.free_idx[SLOT_W-1:0];
                           rsp_slot_in   = lkp.free_idx[3:0];
                        end
                        len_wr_en       = 1'b1;
                        len_wr_data     = dlen;
                        rx_offset_in    = '0;
                        rx_remaining_in = dlen;
                        rsp_count_in    = dlen_clamp[11:0];
                     end
                  end
                  KIND_PAYLOAD: begin
                     // drop bytes with no armed fill
                     if (rx_remaining_ff != '0) begin
                        pay_wr_en       = 1'b1;
                        rx_offset_in    = rx_offset_ff + 1'b1;
                        rx_remaining_in = rx_remaining_ff - 1'b1;
                     end
                  end
                  KIND_RECEIVE: begin
                     if (lkp.hit) begin
                        // fetch stored length, finish next cycle
                        len_rd_en    = 1'b1;
                        pend_read_in = 1'b0;
                        pend_idx_in  = lkp.hit_idx;
                        pend_max_in  = req_max_length;
                        state_in     = S_WAIT;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_count_in = '0;
                        rsp_byte_in  = '0;
                        if (lkp.free) begin
                           bind_en       = 1'b1;
                           len_wr_en     = 1'b1;
                           len_wr_addr   = lkp.free_idx[SLOT_W-1:0];
                           len_wr_data   = '0;
                           rsp_status_in = ST_BOUND;
                           rsp_slot_in   = lkp.free_idx[3:0];
                        end else begin
                           rsp_status_in = ST_TABLE_FULL;
                           rsp_slot_in   = '0;
                        end
                     end
                  end
                  KIND_READ: begin
                     pay_rd_en        = 1'b1;
                     pend_read_in     = 1'b1;
                     pend_idx_in      = slot_idx_type'(req_slot_index);
                     pend_in_range_in = read_in_range;
                     state_in         = S_WAIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WAIT: begin
            // response register is known free here
            rsp_valid_in = 1'b1;
            rsp_slot_in  = pend_idx_ff[3:0];
            state_in     = S_IDLE;
            if (pend_read_ff) begin
               rsp_status_in = ST_BYTE;
               rsp_count_in  = '0;
               rsp_byte_in   = pend_in_range_ff ? pay_rd_data : 8'h00;
            end else begin
               rsp_byte_in = '0;
               if (len_rd_data == '0) begin
                  rsp_status_in = ST_NODATA;
                  rsp_count_in  = '0;
               end else begin
                  // consume the stored datagram
                  rsp_status_in = ST_DATA;
                  rsp_count_in  = recv_n[11:0];
                  len_wr_en     = 1'b1;
                  len_wr_addr   = pend_idx_ff[SLOT_W-1:0];
                  len_wr_data   = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rx_slot_ff      <= '0;
         rx_offset_ff    <= '0;
         rx_remaining_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rx_slot_ff      <= rx_slot_in;
         rx_offset_ff    <= rx_offset_in;
         rx_remaining_ff <= rx_remaining_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      pend_read_ff     <= pend_read_in;
      pend_idx_ff      <= pend_idx_in;
      pend_max_ff      <= pend_max_in;
      pend_in_range_ff <= pend_in_range_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_slot_ff      <= rsp_slot_in;
      rsp_count_ff     <= rsp_count_in;
      rsp_byte_ff      <= rsp_byte_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_byte_ff, rsp_count_ff, rsp_slot_ff};

`ifndef SYNTHESIS
   a_fill_in_buffer: assert property (@(posedge clock) disable iff (reset)
      (32'(rx_offset_ff) + 32'(rx_remaining_ff)) <= 32'(BUF_BYTES)
      || (rx_remaining_ff == '0))
      else $error("payload fill runs past the slot buffer");

   a_wait_rsp_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT) |-> !rsp_valid_ff)
      else $error("pending response would overwrite a waiting one");

   a_read_one_wait: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_kind == KIND_READ)) |=> (state_ff == S_WAIT) ##1 rsp_valid_ff)
      else $error("read request did not respond after one wait cycle");
`endif

endmodule
